// ===== src/hrnt_pkg.sv =====
// Package for the hash ring node table: shared types, codes and the CRC-32 byte step.
// No dependencies. Used by the queue, the front, the engine, the top and the testbench.
package hrnt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int CMDQ_DEPTH        = 2;
  localparam int CMDQ_PTR_W        = $clog2(CMDQ_DEPTH);

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  typedef enum logic [1:0] {
    OP_FIND = 2'd0,
    OP_ADD  = 2'd1,
    OP_DEL  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // one finished key, handed from the hashing front to the table engine
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] hash;
    logic [31:0] addr;
    logic [15:0] port;
  } cmd_t;

  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] addr;
    logic [15:0] port;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_CHECK,
    BK_EXEC,
    BK_INS_RD,
    BK_INS_WR,
    BK_DEL_RD,
    BK_DEL_WR
  } bk_state_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/hrnt_in_if.sv =====
// Input channel of the hash ring node table: valid/ready plus one key byte beat.
// Depends on nothing.
interface hrnt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  key_byte;
  logic        last_byte;
  logic [31:0] node_address;
  logic [15:0] node_port;

  modport source (output valid, opcode, key_byte, last_byte, node_address, node_port,
                  input ready);
  modport sink (input valid, opcode, key_byte, last_byte, node_address, node_port,
                output ready);
endinterface

// ===== src/hrnt_out_if.sv =====
// Result channel of the hash ring node table: valid/ready plus one result beat.
// Depends on nothing.
interface hrnt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_address;
  logic [15:0] found_port;
  logic [31:0] key_hash;

  modport source (output valid, status, found_address, found_port, key_hash,
                  input ready);
  modport sink (input valid, status, found_address, found_port, key_hash,
                output ready);
endinterface

// ===== src/hrnt_cmd_q.sv =====
// Small command queue between the hashing front and the table engine.
// Depends on hrnt_pkg (cmd_t, queue depth).
module hrnt_cmd_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hrnt_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output hrnt_pkg::cmd_t  pop_data,
  output logic            not_empty
);

  localparam int CNT_W = $clog2(hrnt_pkg::CMDQ_DEPTH + 1);

  hrnt_pkg::cmd_t                    slot_r [hrnt_pkg::CMDQ_DEPTH];
  logic [hrnt_pkg::CMDQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [hrnt_pkg::CMDQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(hrnt_pkg::CMDQ_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/hrnt_front.sv =====
// Hashing front: takes key byte beats, runs CRC-32, queues a command on the last byte.
// Depends on hrnt_pkg and hrnt_in_if.
module hrnt_front (
  input  logic            clk,
  input  logic            rst_n,
  hrnt_in_if.sink         in_ch,
  output logic            q_push,
  output hrnt_pkg::cmd_t  q_cmd,
  input  logic            q_full
);

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] crc_step;
  logic        beat;

  assign in_ch.ready = !q_full;
  assign beat        = in_ch.valid && in_ch.ready;
  assign crc_step    = hrnt_pkg::crc_byte(crc_r, in_ch.key_byte);

  assign q_push       = beat && in_ch.last_byte;
  assign q_cmd.opcode = in_ch.opcode;
  assign q_cmd.hash   = ~crc_step;
  assign q_cmd.addr   = in_ch.node_address;
  assign q_cmd.port   = in_ch.node_port;

  always_comb begin
    crc_nxt = crc_r;
    if (beat) begin
      // restart the accumulator once a key is complete
      crc_nxt = in_ch.last_byte ? hrnt_pkg::CRC_INIT : crc_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= hrnt_pkg::CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule

// ===== src/hrnt_back.sv =====
// Table engine: sorted node table in a single-port-write memory, scan/shift sequencer,
// and the result register. Depends on hrnt_pkg and hrnt_out_if.
module hrnt_back #(
  parameter int TABLE_ENTRIES = hrnt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  hrnt_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  hrnt_out_if.source      out_ch
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  hrnt_pkg::entry_t    tbl_mem [TABLE_ENTRIES];
  hrnt_pkg::entry_t    rd_data_r;

  hrnt_pkg::bk_state_t state_r, state_nxt;
  hrnt_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic                hit_r, hit_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [31:0]         fa_r, fa_nxt;
  logic [15:0]         fp_r, fp_nxt;
  logic [31:0]         kh_r, kh_nxt;

  logic                rd_en;
  logic [IDX_W-1:0]    rd_idx;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  hrnt_pkg::entry_t    wr_data;
  logic                fin;
  logic [1:0]          fin_status;
  logic [CNT_W-1:0]    idx_dec;
  logic [CNT_W-1:0]    idx_inc;
  hrnt_pkg::entry_t    new_entry;

  assign idx_dec        = idx_r - 1'b1;
  assign idx_inc        = idx_r + 1'b1;
  assign new_entry.hash = cmd_r.hash;
  assign new_entry.addr = cmd_r.addr;
  assign new_entry.port = cmd_r.port;

  assign q_pop = (state_r == hrnt_pkg::BK_IDLE) && q_valid && !out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hrnt_pkg::BK_IDLE: begin
        if (q_pop) state_nxt = hrnt_pkg::BK_SCAN;
      end
      hrnt_pkg::BK_SCAN: begin
        state_nxt = (idx_r == count_r) ? hrnt_pkg::BK_EXEC : hrnt_pkg::BK_CHECK;
      end
      hrnt_pkg::BK_CHECK: begin
        state_nxt = (rd_data_r.hash >= cmd_r.hash) ? hrnt_pkg::BK_EXEC : hrnt_pkg::BK_SCAN;
      end
      hrnt_pkg::BK_EXEC: begin
        state_nxt = hrnt_pkg::BK_IDLE;
        if (cmd_r.opcode == hrnt_pkg::OP_ADD && !hit_r && count_r != FULL_CNT &&
            pos_r != count_r) begin
          state_nxt = hrnt_pkg::BK_INS_RD;
        end else if (cmd_r.opcode == hrnt_pkg::OP_DEL && hit_r) begin
          state_nxt = hrnt_pkg::BK_DEL_RD;
        end
      end
      hrnt_pkg::BK_INS_RD: begin
        state_nxt = (idx_r == pos_r) ? hrnt_pkg::BK_IDLE : hrnt_pkg::BK_INS_WR;
      end
      hrnt_pkg::BK_INS_WR: begin
        state_nxt = hrnt_pkg::BK_INS_RD;
      end
      hrnt_pkg::BK_DEL_RD: begin
        state_nxt = (idx_inc == count_r) ? hrnt_pkg::BK_IDLE : hrnt_pkg::BK_DEL_WR;
      end
      hrnt_pkg::BK_DEL_WR: begin
        state_nxt = hrnt_pkg::BK_DEL_RD;
      end
      default: state_nxt = hrnt_pkg::BK_IDLE;
    endcase
  end

  // sequencer outputs and datapath
  always_comb begin
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    hit_nxt    = hit_r;
    count_nxt  = count_r;
    rd_en      = 1'b0;
    rd_idx     = idx_r[IDX_W-1:0];
    wr_en      = 1'b0;
    wr_idx     = idx_r[IDX_W-1:0];
    wr_data    = new_entry;
    fin        = 1'b0;
    fin_status = hrnt_pkg::ST_NOT_FOUND;
    fa_nxt     = fa_r;
    fp_nxt     = fp_r;
    unique case (state_r)
      hrnt_pkg::BK_IDLE: begin
        if (q_pop) begin
          cmd_nxt = q_cmd;
          idx_nxt = '0;
        end
      end
      hrnt_pkg::BK_SCAN: begin
        if (idx_r == count_r) begin
          pos_nxt = idx_r;
          hit_nxt = 1'b0;
        end else begin
          rd_en = 1'b1;
        end
      end
      hrnt_pkg::BK_CHECK: begin
        if (rd_data_r.hash >= cmd_r.hash) begin
          pos_nxt = idx_r;
          hit_nxt = (rd_data_r.hash == cmd_r.hash);
        end else begin
          idx_nxt = idx_inc;
        end
      end
      hrnt_pkg::BK_EXEC: begin
        fa_nxt = '0;
        fp_nxt = '0;
        case (cmd_r.opcode)
          hrnt_pkg::OP_FIND: begin
            fin = 1'b1;
            if (pos_r != count_r) begin
              // rd_data_r still holds the entry at the stop position
              fin_status = hrnt_pkg::ST_OK;
              fa_nxt     = rd_data_r.addr;
              fp_nxt     = rd_data_r.port;
            end
          end
          hrnt_pkg::OP_ADD: begin
            if (hit_r) begin
              fin        = 1'b1;
              fin_status = hrnt_pkg::ST_OK;
              wr_en      = 1'b1;
              wr_idx     = pos_r[IDX_W-1:0];
            end else if (count_r == FULL_CNT) begin
              fin        = 1'b1;
              fin_status = hrnt_pkg::ST_FULL;
            end else if (pos_r == count_r) begin
              fin        = 1'b1;
              fin_status = hrnt_pkg::ST_OK;
              wr_en      = 1'b1;
              wr_idx     = pos_r[IDX_W-1:0];
              count_nxt  = count_r + 1'b1;
            end else begin
              idx_nxt = count_r;
            end
          end
          hrnt_pkg::OP_DEL: begin
            if (hit_r) begin
              idx_nxt = pos_r;
            end else begin
              fin = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      hrnt_pkg::BK_INS_RD: begin
        if (idx_r == pos_r) begin
          // gap is open: drop the new entry in
          fin        = 1'b1;
          fin_status = hrnt_pkg::ST_OK;
          wr_en      = 1'b1;
          count_nxt  = count_r + 1'b1;
        end else begin
          rd_en  = 1'b1;
          rd_idx = idx_dec[IDX_W-1:0];
        end
      end
      hrnt_pkg::BK_INS_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data_r;
        idx_nxt = idx_dec;
      end
      hrnt_pkg::BK_DEL_RD: begin
        if (idx_inc == count_r) begin
          fin        = 1'b1;
          fin_status = hrnt_pkg::ST_OK;
          count_nxt  = count_r - 1'b1;
        end else begin
          rd_en  = 1'b1;
          rd_idx = idx_inc[IDX_W-1:0];
        end
      end
      hrnt_pkg::BK_DEL_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data_r;
        idx_nxt = idx_inc;
      end
      default: ;
    endcase
  end

  // result register; the engine only starts while it is empty
  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    kh_nxt        = kh_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin) begin
      out_valid_nxt = 1'b1;
      status_nxt    = fin_status;
      kh_nxt        = cmd_r.hash;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.found_address = fa_r;
  assign out_ch.found_port    = fp_r;
  assign out_ch.key_hash      = kh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hrnt_pkg::BK_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
    fa_r     <= fa_nxt;
    fp_r     <= fp_nxt;
    kh_r     <= kh_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= tbl_mem[rd_idx];
    end
  end

endmodule

// ===== src/hash_ring_node_table.sv =====
// Hash ring node table: CRC-32 keyed, sorted node table with find/add/delete.
// Channels: in_ch takes one key byte per beat (valid/ready); on the beat with last_byte
// set, the opcode and node fields are sampled and the finished key is queued. out_ch
// gives one result beat per key (status, found node, key hash).
// Throughput: key bytes are taken one per cycle while the two-entry command queue has
// room; in_ch.ready drops only when it is full. The table engine works one key at a time:
// it takes the key from the queue, compares table entries in order, each by a registered
// read and then a check (past the last entry the scan stops without a read), acts, and
// for an insert or delete that shifts the table moves each entry by a read and then a
// write, then finishes. The single memory read port, read registered, sets that split
// into a read step and a check or write step.
// A stalled out_ch holds the result; the engine waits, the queue fills, then in_ch
// stalls. Synchronous active-low reset clears the CRC accumulator, the entry count,
// the queue and the result valid flag; the table memory needs no clearing.
// Depends on hrnt_pkg, hrnt_in_if, hrnt_out_if, hrnt_front, hrnt_cmd_q, hrnt_back.
module hash_ring_node_table #(
  parameter int TABLE_ENTRIES = hrnt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  hrnt_in_if.sink      in_ch,
  hrnt_out_if.source   out_ch
);

  logic            q_push;
  hrnt_pkg::cmd_t  q_push_cmd;
  logic            q_full;
  logic            q_pop;
  hrnt_pkg::cmd_t  q_pop_cmd;
  logic            q_valid;

  hrnt_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_cmd  (q_push_cmd),
    .q_full (q_full)
  );

  hrnt_cmd_q u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_cmd),
    .not_empty (q_valid)
  );

  hrnt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_pop_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== tb/sv/hash_ring_node_table_chk.sv =====
// Result checker for the hash ring node table: watches both channels, keeps its own
// CRC-32 and sorted node ring, and compares every result beat with the oldest prediction.
// Depends on hrnt_pkg, hrnt_in_if and hrnt_out_if.
`timescale 1ns / 100ps

module hash_ring_node_table_chk #(
  parameter int TABLE_ENTRIES = hrnt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  hrnt_in_if   in_ch,
  hrnt_out_if  out_ch,
  output int   fail_count,
  output int   replies_pending
);

  typedef struct packed {
    hrnt_pkg::status_t status;
    logic [31:0]       addr;
    logic [15:0]       port;
    logic [31:0]       hash;
  } ring_reply_t;

  logic [31:0] key_crc;
  logic [31:0] ring_hash [TABLE_ENTRIES];
  logic [31:0] ring_addr [TABLE_ENTRIES];
  logic [15:0] ring_port [TABLE_ENTRIES];
  int          ring_cnt;
  ring_reply_t pending_replies [$];

  // reflected CRC-32: fold each data bit into the feedback instead of xoring the byte first
  function automatic logic [31:0] crc_advance(logic [31:0] c, logic [7:0] b);
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (hrnt_pkg::CRC_POLY & {32{c[0] ^ b[k]}});
    end
    return c;
  endfunction

  function automatic ring_reply_t run_ring_op(logic [1:0] op, logic [31:0] h,
                                              logic [31:0] a, logic [15:0] p);
    ring_reply_t r;
    int          pos;
    bit          hit;
    r.status = hrnt_pkg::ST_NOT_FOUND;
    r.addr   = '0;
    r.port   = '0;
    r.hash   = h;
    pos = 0;
    while (pos < ring_cnt && ring_hash[pos] < h) pos++;
    hit = (pos < ring_cnt) && (ring_hash[pos] == h);
    case (op)
      hrnt_pkg::OP_FIND: begin
        // no wrap-around: past the largest hash there is no node
        if (pos < ring_cnt) begin
          r.addr   = ring_addr[pos];
          r.port   = ring_port[pos];
          r.status = hrnt_pkg::ST_OK;
        end
      end
      hrnt_pkg::OP_ADD: begin
        if (hit) begin
          ring_addr[pos] = a;
          ring_port[pos] = p;
          r.status = hrnt_pkg::ST_OK;
        end else if (ring_cnt >= TABLE_ENTRIES) begin
          r.status = hrnt_pkg::ST_FULL;
        end else begin
          for (int i = ring_cnt; i > pos; i--) begin
            ring_hash[i] = ring_hash[i-1];
            ring_addr[i] = ring_addr[i-1];
            ring_port[i] = ring_port[i-1];
          end
          ring_hash[pos] = h;
          ring_addr[pos] = a;
          ring_port[pos] = p;
          ring_cnt++;
          r.status = hrnt_pkg::ST_OK;
        end
      end
      hrnt_pkg::OP_DEL: begin
        if (hit) begin
          for (int i = pos; i < ring_cnt - 1; i++) begin
            ring_hash[i] = ring_hash[i+1];
            ring_addr[i] = ring_addr[i+1];
            ring_port[i] = ring_port[i+1];
          end
          ring_cnt--;
          r.status = hrnt_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic match_field(string what, logic [31:0] want, logic [31:0] got,
                             inout int errs);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    ring_reply_t want;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      key_crc  = hrnt_pkg::CRC_INIT;
      ring_cnt = 0;
      pending_replies.delete();
      fail_count      <= 0;
      replies_pending <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        key_crc = crc_advance(key_crc, in_ch.key_byte);
        if (in_ch.last_byte) begin
          pending_replies.push_back(run_ring_op(in_ch.opcode, ~key_crc,
                                                in_ch.node_address, in_ch.node_port));
          key_crc = hrnt_pkg::CRC_INIT;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got status %0d hash %h",
                   $time, out_ch.status, out_ch.key_hash);
          errs++;
        end else begin
          want = pending_replies.pop_front();
          match_field("status", 32'(want.status), 32'(out_ch.status), errs);
          match_field("found_address", want.addr, out_ch.found_address, errs);
          match_field("found_port", 32'(want.port), 32'(out_ch.found_port), errs);
          match_field("key_hash", want.hash, out_ch.key_hash, errs);
        end
      end
      fail_count      <= fail_count + errs;
      replies_pending <= pending_replies.size();
    end
  end

endmodule

// ===== tb/sv/hash_ring_node_table_tb.sv =====
// Top of the hash ring node table testbench: clock, reset, key byte stimulus and result
// back-pressure; the checker beside the block predicts and compares.
// Depends on hrnt_pkg, hrnt_in_if, hrnt_out_if, hash_ring_node_table, hash_ring_node_table_chk.
`timescale 1ns / 100ps

module hash_ring_node_table_tb;

  localparam int          TABLE_ENTRIES = 16;
  localparam int          KEY_POOL      = 24;
  localparam int          CYCLE_LIMIT   = 600000;
  localparam logic [1:0]  OP_RSVD       = 2'd3;

  logic clk;
  logic rst_n;
  int   chk_fails;
  int   chk_pending;

  hrnt_in_if  in_ch ();
  hrnt_out_if out_ch ();

  hash_ring_node_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hash_ring_node_table_chk #(.TABLE_ENTRIES(TABLE_ENTRIES)) i_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (chk_fails),
    .replies_pending (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  logic [31:0] pool_addr [KEY_POOL];
  logic [15:0] pool_port [KEY_POOL];
  logic [7:0]  key_text [$];
  int          beats_sent;
  bit          quiet_key;
  bit          long_hold_req;

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic put_beat(logic [1:0] op, logic [7:0] b, logic last,
                          logic [31:0] a, logic [15:0] p);
    int gap;
    gap = pick_gap(quiet_key);
    if (gap > 0) begin
      in_ch.valid    <= 1'b0;
      in_ch.key_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.key_byte     <= b;
    in_ch.last_byte    <= last;
    in_ch.node_address <= a;
    in_ch.node_port    <= p;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  // earlier bytes carry random opcode and node fields; only the last beat's count
  task automatic send_key(logic [1:0] op, logic [31:0] a, logic [15:0] p);
    quiet_key = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < key_text.size(); i++) begin
      if (i == key_text.size() - 1) put_beat(op, key_text[i], 1'b1, a, p);
      else put_beat(2'($urandom), key_text[i], 1'b0, $urandom, 16'($urandom));
    end
  endtask

  task automatic load_node_key(int k);
    string s;
    s = $sformatf("%0d.%0d.%0d.%0d:%0d", pool_addr[k][31:24], pool_addr[k][23:16],
                  pool_addr[k][15:8], pool_addr[k][7:0], pool_port[k]);
    key_text.delete();
    for (int i = 0; i < s.len(); i++) key_text.push_back(s[i]);
  endtask

  task automatic load_topic();
    int len;
    len = $urandom_range(1, 12);
    key_text.delete();
    repeat (len) key_text.push_back(8'($urandom));
  endtask

  // drop valid so the last beat is not taken again, then wait for every result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
  endtask

  task automatic run_mix(int beat_goal);
    int r;
    int k;
    while (beats_sent < beat_goal) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, KEY_POOL - 1);
      if (r < 20) begin
        load_topic();
        send_key(hrnt_pkg::OP_FIND, $urandom, 16'($urandom));
      end else if (r < 38) begin
        load_node_key(k);
        send_key(hrnt_pkg::OP_FIND, $urandom, 16'($urandom));
      end else if (r < 66) begin
        load_node_key(k);
        // a changed node under the same text shows up as an overwrite
        if ($urandom_range(0, 2) == 0) send_key(hrnt_pkg::OP_ADD, $urandom, 16'($urandom));
        else send_key(hrnt_pkg::OP_ADD, pool_addr[k], pool_port[k]);
      end else if (r < 88) begin
        load_node_key(k);
        send_key(hrnt_pkg::OP_DEL, $urandom, 16'($urandom));
      end else if (r < 94) begin
        load_topic();
        send_key(hrnt_pkg::OP_DEL, $urandom, 16'($urandom));
      end else if (r < 97) begin
        load_node_key(k);
        send_key(OP_RSVD, $urandom, 16'($urandom));
      end else begin
        load_topic();
        send_key(hrnt_pkg::OP_ADD, $urandom, 16'($urandom));
      end
    end
  endtask

  // result side: random stalls, quiet stretches, and one long hold-off on request
  initial begin : result_sink
    int stall_left;
    int mode_left;
    bit no_stall;
    stall_left   = 0;
    mode_left    = 0;
    no_stall     = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = 400;
      end
      if (mode_left == 0) begin
        no_stall  = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 250);
      end
      mode_left--;
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!no_stall) stall_left = pick_gap(1'b0);
      end
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    in_ch.valid        = 1'b0;
    in_ch.opcode       = hrnt_pkg::OP_FIND;
    in_ch.key_byte     = '0;
    in_ch.last_byte    = 1'b0;
    in_ch.node_address = '0;
    in_ch.node_port    = '0;
    beats_sent         = 0;
    quiet_key          = 1'b0;
    long_hold_req      = 1'b0;
    rst_n              = 1'b0;
    for (int k = 0; k < KEY_POOL; k++) begin
      pool_addr[k] = $urandom;
      pool_port[k] = 16'($urandom);
    end
    pool_addr[0] = '1;
    pool_port[0] = '1;
    pool_addr[1] = '0;
    pool_port[1] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty ring, unused opcode, extreme node fields, overwrite, double delete
    key_text = {8'h00};
    send_key(hrnt_pkg::OP_FIND, '1, '1);
    key_text = {8'hFF};
    send_key(OP_RSVD, '1, '1);
    key_text = {8'h00};
    send_key(hrnt_pkg::OP_ADD, 32'hFFFF_FFFF, 16'hFFFF);
    key_text = {8'hFF};
    send_key(hrnt_pkg::OP_ADD, 32'h0000_0000, 16'h0000);
    key_text = {8'h00};
    send_key(hrnt_pkg::OP_FIND, '0, '0);
    key_text = {8'hFF};
    send_key(hrnt_pkg::OP_FIND, '0, '0);
    key_text = {8'h00};
    send_key(hrnt_pkg::OP_ADD, 32'h5A5A_A5A5, 16'hA55A);
    key_text = {8'h00};
    send_key(hrnt_pkg::OP_FIND, '0, '0);
    key_text = {8'hFF};
    send_key(hrnt_pkg::OP_DEL, '1, '1);
    key_text = {8'hFF};
    send_key(hrnt_pkg::OP_DEL, '1, '1);
    key_text = {8'h7F, 8'h80};
    send_key(hrnt_pkg::OP_ADD, 32'h8000_0001, 16'h8001);
    key_text = {8'h7F, 8'h80};
    send_key(hrnt_pkg::OP_DEL, '0, '0);
    key_text = {8'h00};
    send_key(hrnt_pkg::OP_DEL, '0, '0);
    key_text = {8'h00};
    send_key(hrnt_pkg::OP_FIND, '0, '0);
    wait_drained();

    // fill the ring past capacity so the last adds report full
    for (int k = 0; k < 20; k++) begin
      load_node_key(k);
      send_key(hrnt_pkg::OP_ADD, pool_addr[k], pool_port[k]);
    end
    wait_drained();

    long_hold_req = 1'b1;
    run_mix(900);
    wait_drained();

    // empty the ring of node keys, then look up on what is left
    for (int k = 0; k < KEY_POOL; k++) begin
      load_node_key(k);
      send_key(hrnt_pkg::OP_DEL, $urandom, 16'($urandom));
    end
    repeat (3) begin
      load_topic();
      send_key(hrnt_pkg::OP_FIND, $urandom, 16'($urandom));
    end
    run_mix(1650);
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (100) @(posedge clk);
    if (chk_fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
